// ----- design/wfw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wfw_pkg
// shared constants, types and helper functions of the window fold/wrap core
// ----------------------------------------------------------------------------
package wfw_pkg;

    localparam int PASS_LIMIT  = 10;
    localparam int FRAC_BITS   = 12;

    localparam int IN_W        = 17;
    localparam int OUT_W       = 20;
    localparam int CNT_OUT_W   = 4;
    localparam int KNOB_W      = 16;
    localparam int MODE_W      = 2;
    localparam int MASK_W      = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int N_IN        = 6;
    localparam int N_LANES     = 4;
    localparam int N_CH        = 2;

    // working width of the fold datapath, room for the value to swing outside the window
    localparam int VAL_W       = 26;
    localparam int LOOP_W      = $clog2(PASS_LIMIT + 1);
    localparam int CMP_W       = (LOOP_W > CNT_OUT_W) ? LOOP_W : CNT_OUT_W;

    localparam int ONE         = 1 << FRAC_BITS;
    localparam int SIZE_MIN    = ONE / 2;
    localparam int SIZE_MAX    = 10 * ONE;
    localparam int OFFS_MAX    = 5 * ONE;
    localparam int OUT_MAX     = (1 << (OUT_W - 1)) - 1;
    localparam int CNT_MAX     = (1 << CNT_OUT_W) - 1;

    localparam int IN_TDATA_W  = ((N_IN * IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((N_LANES * (OUT_W + CNT_OUT_W) + 7) / 8) * 8;

    localparam logic [KNOB_W-1:0] SIZE_KNOB_RST = KNOB_W'(40960);

    // connected_mask bit positions
    localparam int MASK_SIG_A  = 0;
    localparam int MASK_SIG_B  = 1;
    localparam int MASK_SIZE_A = 2;
    localparam int MASK_OFFS_A = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_KNOB_A    = 3'd0,
        REG_SIZE_KNOB_B    = 3'd1,
        REG_OFFSET_KNOB_A  = 3'd2,
        REG_OFFSET_KNOB_B  = 3'd3,
        REG_MODE_BITS      = 3'd4,
        REG_CONNECTED_MASK = 3'd5
    } t_cfg_reg;

    // window of one channel, edges in doubled units
    typedef struct packed {
        logic signed [VAL_W-1:0] size;
        logic signed [VAL_W:0]   lo2;
        logic signed [VAL_W:0]   hi2;
        logic                    wrap;
    } t_window;

    typedef struct packed {
        logic busy;
        logic fin;
    } t_lane_status;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] hi;
        logic signed [VAL_W-1:0] lo;
        hi = VAL_W'(OUT_MAX);
        lo = -hi - VAL_W'(1);
        if (v > hi) begin
            return OUT_W'(hi);
        end else if (v < lo) begin
            return OUT_W'(lo);
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic logic [CNT_OUT_W-1:0] sat_cnt(input logic [LOOP_W-1:0] c);
        logic [CMP_W-1:0] cx;
        cx = CMP_W'(c);
        if (cx > CMP_W'(CNT_MAX)) begin
            return CNT_OUT_W'(CNT_MAX);
        end
        return cx[CNT_OUT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/wfw_window.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wfw_window
// forms the clamped window of one channel from knobs and control voltages
// ----------------------------------------------------------------------------
module wfw_window (
    input  logic                                  i_clk,
    input  logic                                  i_load,
    input  logic [wfw_pkg::KNOB_W-1:0]            i_size_knob,
    input  logic signed [wfw_pkg::KNOB_W-1:0]     i_offs_knob,
    input  logic signed [wfw_pkg::IN_W-1:0]       i_size_cv,
    input  logic signed [wfw_pkg::IN_W-1:0]       i_offs_cv,
    input  logic                                  i_size_conn,
    input  logic                                  i_offs_conn,
    input  logic                                  i_wrap,
    output wfw_pkg::t_window                      o_win
);

    logic signed [wfw_pkg::IN_W:0]         cv_x;
    logic signed [wfw_pkg::IN_W:0]         cv_abs;
    logic signed [wfw_pkg::IN_W+1:0]       size_sum;
    logic signed [wfw_pkg::IN_W+1:0]       offs_sum;
    logic signed [wfw_pkg::VAL_W-1:0]      size_c;
    logic signed [wfw_pkg::VAL_W-1:0]      offs_c;
    logic signed [wfw_pkg::VAL_W:0]        offs2;
    wfw_pkg::t_window                      n_win;
    wfw_pkg::t_window                      r_win;

    always_comb begin
        cv_x   = (wfw_pkg::IN_W + 1)'(i_size_cv);
        cv_abs = '0;
        if (i_size_conn) begin
            cv_abs = (cv_x < 0) ? -cv_x : cv_x;
        end
        size_sum = $signed({3'b000, i_size_knob}) + (wfw_pkg::IN_W + 2)'(cv_abs);
        offs_sum = (wfw_pkg::IN_W + 2)'(i_offs_knob);
        if (i_offs_conn) begin
            offs_sum = offs_sum + (wfw_pkg::IN_W + 2)'(i_offs_cv);
        end

        if (int'(size_sum) < wfw_pkg::SIZE_MIN) begin
            size_c = wfw_pkg::VAL_W'(wfw_pkg::SIZE_MIN);
        end else if (int'(size_sum) > wfw_pkg::SIZE_MAX) begin
            size_c = wfw_pkg::VAL_W'(wfw_pkg::SIZE_MAX);
        end else begin
            size_c = wfw_pkg::VAL_W'(size_sum);
        end

        if (int'(offs_sum) < -wfw_pkg::OFFS_MAX) begin
            offs_c = wfw_pkg::VAL_W'(-wfw_pkg::OFFS_MAX);
        end else if (int'(offs_sum) > wfw_pkg::OFFS_MAX) begin
            offs_c = wfw_pkg::VAL_W'(wfw_pkg::OFFS_MAX);
        end else begin
            offs_c = wfw_pkg::VAL_W'(offs_sum);
        end

        offs2      = $signed({offs_c, 1'b0});
        n_win.size = size_c;
        n_win.lo2  = offs2 - (wfw_pkg::VAL_W + 1)'(size_c);
        n_win.hi2  = offs2 + (wfw_pkg::VAL_W + 1)'(size_c);
        n_win.wrap = i_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_win <= n_win;
        end
    end

    assign o_win = r_win;

endmodule
`default_nettype wire

// ----- design/wfw_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wfw_lane
// folds or wraps one value into its window, one pass per cycle
// ----------------------------------------------------------------------------
module wfw_lane (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [wfw_pkg::VAL_W-1:0]      i_init,
    input  wfw_pkg::t_window                      i_win,
    output wfw_pkg::t_lane_status                 o_status,
    output logic signed [wfw_pkg::OUT_W-1:0]      o_value,
    output logic [wfw_pkg::CNT_OUT_W-1:0]         o_count
);

    logic                               r_busy;
    logic                               r_fin;
    logic signed [wfw_pkg::VAL_W-1:0]   r_val;
    logic [wfw_pkg::LOOP_W-1:0]         r_loops;

    logic signed [wfw_pkg::VAL_W:0]     v2;
    logic signed [wfw_pkg::VAL_W:0]     val_x;
    logic signed [wfw_pkg::VAL_W-1:0]   nv;
    logic signed [wfw_pkg::VAL_W:0]     nv2;
    logic                               in_win;
    logic                               last;

    always_comb begin
        v2    = $signed({r_val, 1'b0});
        val_x = (wfw_pkg::VAL_W + 1)'(r_val);
        nv    = r_val;
        if (v2 > i_win.hi2) begin
            nv = i_win.wrap ? r_val - i_win.size : wfw_pkg::VAL_W'(i_win.hi2 - val_x);
        end else if (v2 < i_win.lo2) begin
            nv = i_win.wrap ? r_val + i_win.size : wfw_pkg::VAL_W'(i_win.lo2 - val_x);
        end
        nv2    = $signed({nv, 1'b0});
        // an edge value is not inside, so it keeps passing until the limit
        in_win = (nv2 < i_win.hi2) && (nv2 > i_win.lo2);
        last   = in_win || (r_loops >= wfw_pkg::LOOP_W'(wfw_pkg::PASS_LIMIT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_fin  <= 1'b0;
        end else if (r_busy && last) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val   <= i_init;
            r_loops <= '0;
        end else if (r_busy) begin
            r_val <= nv;
            if (!last) begin
                r_loops <= r_loops + 1'b1;
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.fin  = r_fin;
    assign o_value       = wfw_pkg::sat_out(r_val);
    assign o_count       = wfw_pkg::sat_cnt(r_loops);

endmodule
`default_nettype wire

// ----- design/window_fold_wrap_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// window_fold_wrap_core
// dual-channel window folder / wrapper with four parallel fold lanes
// ----------------------------------------------------------------------------
// One item is taken at a time. After acceptance the setup state forms both windows
// and seeds the four lanes (signal and negated signal of each channel), then
// each lane takes one fold or wrap pass per cycle until it finishes, 1 to
// PASS_LIMIT+1 passes (1 to 11), and the slowest lane sets the length. Once the
// last lane sets its finish flag the block moves to the done state, which loads
// the result into the output register as soon as that register is free, and
// s_axis_tready rises again with that load; a result left waiting on m_axis
// holds the next item's result until it is taken. Configuration writes land
// at once and are expected only while no item is in flight.
module window_fold_wrap_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [wfw_pkg::CFG_IDX_W-1:0]         i_cfg_addr,
    input  logic [wfw_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    // input items
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sig_a, sig_b, size_cv_a, size_cv_b, offset_cv_a, offset_cv_b, zero pad
    input  logic [wfw_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // result items
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // main_a, inv_a, main_b, inv_b, folds_a, folds_inv_a, folds_b, folds_inv_b
    output logic [wfw_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state                                    r_state;
    t_state                                    n_state;

    logic [wfw_pkg::KNOB_W-1:0]                r_size_knob [wfw_pkg::N_CH];
    logic [wfw_pkg::KNOB_W-1:0]                r_offs_knob [wfw_pkg::N_CH];
    logic [wfw_pkg::MODE_W-1:0]                r_mode;
    logic [wfw_pkg::MASK_W-1:0]                r_mask;

    logic [wfw_pkg::N_IN*wfw_pkg::IN_W-1:0]    r_in;
    logic signed [wfw_pkg::IN_W-1:0]           in_f [wfw_pkg::N_IN];

    logic                                      r_m_valid;
    logic [wfw_pkg::OUT_TDATA_W-1:0]           r_m_data;
    logic [wfw_pkg::OUT_TDATA_W-1:0]           n_m_data;

    logic                                      s_accept;
    logic                                      out_free;
    logic                                      setup;
    logic                                      all_fin;

    logic signed [wfw_pkg::VAL_W-1:0]          sig [wfw_pkg::N_CH];
    logic signed [wfw_pkg::VAL_W-1:0]          lane_init [wfw_pkg::N_LANES];
    wfw_pkg::t_window                          win [wfw_pkg::N_CH];
    wfw_pkg::t_lane_status                     lane_st [wfw_pkg::N_LANES];
    logic signed [wfw_pkg::OUT_W-1:0]          lane_val [wfw_pkg::N_LANES];
    logic [wfw_pkg::CNT_OUT_W-1:0]             lane_cnt [wfw_pkg::N_LANES];
    logic [wfw_pkg::N_LANES-1:0]               fin_vec;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign setup         = (r_state == ST_SETUP);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_knob[0] <= wfw_pkg::SIZE_KNOB_RST;
            r_size_knob[1] <= wfw_pkg::SIZE_KNOB_RST;
            r_offs_knob[0] <= '0;
            r_offs_knob[1] <= '0;
            r_mode         <= '0;
            r_mask         <= '0;
        end else if (i_cfg_we) begin
            case (wfw_pkg::t_cfg_reg'(i_cfg_addr))
                wfw_pkg::REG_SIZE_KNOB_A:    r_size_knob[0] <= i_cfg_wdata;
                wfw_pkg::REG_SIZE_KNOB_B:    r_size_knob[1] <= i_cfg_wdata;
                wfw_pkg::REG_OFFSET_KNOB_A:  r_offs_knob[0] <= i_cfg_wdata;
                wfw_pkg::REG_OFFSET_KNOB_B:  r_offs_knob[1] <= i_cfg_wdata;
                wfw_pkg::REG_MODE_BITS:      r_mode <= i_cfg_wdata[wfw_pkg::MODE_W-1:0];
                wfw_pkg::REG_CONNECTED_MASK: r_mask <= i_cfg_wdata[wfw_pkg::MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in <= s_axis_tdata[wfw_pkg::N_IN*wfw_pkg::IN_W-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < wfw_pkg::N_IN; i++) begin
            in_f[i] = r_in[i*wfw_pkg::IN_W +: wfw_pkg::IN_W];
        end
        // unconnected A reads zero, unconnected B follows A
        sig[0] = r_mask[wfw_pkg::MASK_SIG_A] ? wfw_pkg::VAL_W'(in_f[0]) : '0;
        sig[1] = r_mask[wfw_pkg::MASK_SIG_B] ? wfw_pkg::VAL_W'(in_f[1]) : sig[0];
        for (int c = 0; c < wfw_pkg::N_CH; c++) begin
            lane_init[2*c]     = sig[c];
            lane_init[2*c + 1] = -sig[c];
        end
    end

    for (genvar c = 0; c < wfw_pkg::N_CH; c++) begin : g_ch
        wfw_window u_window (
            .i_clk       (i_clk),
            .i_load      (setup),
            .i_size_knob (r_size_knob[c]),
            .i_offs_knob ($signed(r_offs_knob[c])),
            .i_size_cv   (in_f[2 + c]),
            .i_offs_cv   (in_f[4 + c]),
            .i_size_conn (r_mask[wfw_pkg::MASK_SIZE_A + c]),
            .i_offs_conn (r_mask[wfw_pkg::MASK_OFFS_A + c]),
            .i_wrap      (r_mode[c]),
            .o_win       (win[c])
        );
    end

    for (genvar l = 0; l < wfw_pkg::N_LANES; l++) begin : g_lane
        wfw_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (setup),
            .i_init   (lane_init[l]),
            .i_win    (win[l / 2]),
            .o_status (lane_st[l]),
            .o_value  (lane_val[l]),
            .o_count  (lane_cnt[l])
        );
        assign fin_vec[l] = lane_st[l].fin && !lane_st[l].busy;
    end

    assign all_fin = &fin_vec;

    // merge: pack the four lane results into one item
    always_comb begin
        n_m_data = '0;
        for (int l = 0; l < wfw_pkg::N_LANES; l++) begin
            n_m_data[l*wfw_pkg::OUT_W +: wfw_pkg::OUT_W] = lane_val[l];
            n_m_data[wfw_pkg::N_LANES*wfw_pkg::OUT_W + l*wfw_pkg::CNT_OUT_W +:
                     wfw_pkg::CNT_OUT_W] = lane_cnt[l];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (s_accept) n_state = ST_SETUP;
            ST_SETUP: n_state = ST_RUN;
            ST_RUN:   if (all_fin) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_m_data <= n_m_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
`default_nettype wire

// ----- design/wfw_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wfw_checker
// port-level checks of the window fold/wrap core, bound to the top level
// ----------------------------------------------------------------------------
module wfw_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic [wfw_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

    localparam int CNT_LSB = wfw_pkg::N_LANES * wfw_pkg::OUT_W;
    localparam int CW      = wfw_pkg::CNT_OUT_W;

    // one item at a time: accepting closes the input side
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed or dropped");

    a_pass_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (32'(m_axis_tdata[CNT_LSB +: CW]) <= wfw_pkg::PASS_LIMIT) &&
            (32'(m_axis_tdata[CNT_LSB + CW +: CW]) <= wfw_pkg::PASS_LIMIT) &&
            (32'(m_axis_tdata[CNT_LSB + 2*CW +: CW]) <= wfw_pkg::PASS_LIMIT) &&
            (32'(m_axis_tdata[CNT_LSB + 3*CW +: CW]) <= wfw_pkg::PASS_LIMIT))
        else $error("pass count above limit");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("block not idle after reset");

endmodule

bind window_fold_wrap_core wfw_checker u_wfw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
